>>> rtl/vflt_pkg.sv
// ---------------------------------------------------------------------------
// vflt_pkg
// Shared types, codes and constants of the vblank frame lock tracker.
// ---------------------------------------------------------------------------
package vflt_pkg;

  localparam int LINE_BITS_DEF = 9;

  localparam int OP_W       = 3;
  localparam int BLANK_W    = 9;
  localparam int STEP_W     = 8;
  localparam int JIT_IN_W   = 10;
  localparam int JIT_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int VIOL_W     = 2;
  localparam int STABLE_W   = 2;
  localparam int LOCKED_W   = 6;

  // operations
  localparam logic [OP_W-1:0] OP_RESET  = 3'd0;
  localparam logic [OP_W-1:0] OP_FRAME  = 3'd1;
  localparam logic [OP_W-1:0] OP_LINE   = 3'd2;
  localparam logic [OP_W-1:0] OP_VBLANK = 3'd3;
  localparam logic [OP_W-1:0] OP_JITTER = 3'd4;

  // lock modes
  localparam logic [MODE_W-1:0] MODE_FLOAT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FINAL = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_STEP  = 2'd2;

  localparam logic [STEP_W-1:0] JITTER_STEP_RST = 8'd2;

  localparam int UNDERSCAN_MAX   = 10;
  localparam int VIOLATIONS_MAX  = 2;
  localparam int STABLE_MIN      = 1;
  localparam int FRAMES_TO_FINAL = 30;
  localparam int JITTER_MAX      = 50;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic                       vblank_level;
    logic                       garbage_frame;
    logic signed [JIT_IN_W-1:0] jitter_value;
  } vflt_item_t;

  typedef struct packed {
    logic              leave_blank;
    logic [MODE_W-1:0] lock_mode;
  } vflt_res_t;

endpackage

>>> rtl/vflt_core.sv
// ---------------------------------------------------------------------------
// vflt_core
// Tracker state, configuration registers and combinational event update.
// ---------------------------------------------------------------------------
module vflt_core #(
  parameter int LINE_BITS = vflt_pkg::LINE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  vflt_pkg::vflt_item_t             item_i,
  input  logic                             cfg_we_i,
  input  logic [vflt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vflt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output vflt_pkg::vflt_res_t              res_o
);

  localparam int EW = (LINE_BITS > vflt_pkg::BLANK_W) ? LINE_BITS : vflt_pkg::BLANK_W;
  localparam int TW = EW + 3;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  logic [vflt_pkg::BLANK_W-1:0]  blank_len_q, blank_len_d;
  logic [vflt_pkg::BLANK_W-1:0]  fix_start_q, fix_start_d;
  logic [vflt_pkg::STEP_W-1:0]   step_q, step_d;
  logic [vflt_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic                          vblank_q, vblank_d;
  logic [LINE_BITS-1:0]          line_q, line_d;
  logic [LINE_BITS-1:0]          last_q, last_d;
  logic [vflt_pkg::VIOL_W-1:0]   viol_cnt_q, viol_cnt_d;
  logic [vflt_pkg::STABLE_W-1:0] stable_q, stable_d;
  logic                          violated_q, violated_d;
  logic                          running_q, running_d;
  logic [vflt_pkg::LOCKED_W-1:0] locked_q, locked_d;
  logic signed [vflt_pkg::JIT_W-1:0] jit_q, jit_d;
  logic                          tr;

  always_comb begin
    logic              do_decide;
    logic              reach;
    logic [EW-1:0]     lc_e;
    logic [EW-1:0]     bl_e;
    logic signed [TW-1:0] jo_t, jc_t, base_t, thr_t, lc_t, step_t, j_t, aj_t, ao_t;
    logic [vflt_pkg::BLANK_W-1:0] v;

    blank_len_d = blank_len_q;
    fix_start_d = fix_start_q;
    step_d      = step_q;
    mode_d      = mode_q;
    vblank_d    = vblank_q;
    line_d      = line_q;
    last_d      = last_q;
    viol_cnt_d  = viol_cnt_q;
    stable_d    = stable_q;
    violated_d  = violated_q;
    running_d   = running_q;
    locked_d    = locked_q;
    jit_d       = jit_q;
    tr          = 1'b0;
    do_decide   = 1'b0;
    v           = cfg_data_i;
    step_t      = TW'($signed({1'b0, step_q}));
    jo_t        = TW'(jit_q);
    j_t         = '0;
    aj_t        = '0;
    ao_t        = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vflt_pkg::REG_BLANK_LENGTH: blank_len_d = cfg_data_i;
        vflt_pkg::REG_FIXED_START: begin
          if (v != fix_start_q) begin
            fix_start_d = v;
            mode_d = (v != '0) ? vflt_pkg::MODE_FIXED : vflt_pkg::MODE_FLOAT;
          end
        end
        vflt_pkg::REG_JITTER_STEP: step_d = cfg_data_i[vflt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end else if (fire_i) begin
      unique case (item_i.operation)
        vflt_pkg::OP_RESET: begin
          vblank_d   = 1'b0;
          line_d     = '0;
          viol_cnt_d = '0;
          stable_d   = '0;
          violated_d = 1'b0;
          last_d     = '0;
          running_d  = 1'b0;
          jit_d      = '0;
          if (mode_q != vflt_pkg::MODE_FIXED) mode_d = vflt_pkg::MODE_FLOAT;
        end
        vflt_pkg::OP_FRAME: begin
          line_d     = '0;
          running_d  = 1'b1;
          violated_d = 1'b0;
          if (mode_q == vflt_pkg::MODE_LOCK) begin
            if (locked_q != '1) locked_d = locked_q + 1'b1;
            if (32'(locked_d) > vflt_pkg::FRAMES_TO_FINAL) mode_d = vflt_pkg::MODE_FINAL;
          end
          if (jo_t > 0) begin
            j_t = jo_t - step_t;
            jit_d = (j_t < 0) ? '0 : vflt_pkg::JIT_W'(j_t);
          end else if (jo_t < 0) begin
            j_t = jo_t + step_t;
            jit_d = (j_t > 0) ? '0 : vflt_pkg::JIT_W'(j_t);
          end
        end
        vflt_pkg::OP_LINE: begin
          if (running_q) begin
            if (line_q != LINE_MAX) line_d = line_q + 1'b1;
            do_decide = 1'b1;
          end
        end
        vflt_pkg::OP_VBLANK: begin
          vblank_d = item_i.vblank_level;
          if (running_q && !item_i.vblank_level && vblank_q) do_decide = 1'b1;
        end
        vflt_pkg::OP_JITTER: begin
          j_t = TW'($signed(item_i.jitter_value));
          if (j_t > TW'(vflt_pkg::JITTER_MAX)) j_t = TW'(vflt_pkg::JITTER_MAX);
          if (mode_q == vflt_pkg::MODE_FINAL && j_t < -$signed(TW'(last_q)))
            j_t = -$signed(TW'(last_q));
          if (mode_q == vflt_pkg::MODE_FIXED && j_t < -$signed(TW'(fix_start_q)))
            j_t = -$signed(TW'(fix_start_q));
          if (j_t > 0) j_t = j_t + step_t;
          else if (j_t < 0) j_t = j_t - step_t;
          aj_t = (j_t < 0) ? -j_t : j_t;
          ao_t = (jo_t < 0) ? -jo_t : jo_t;
          if (aj_t > ao_t) jit_d = vflt_pkg::JIT_W'(j_t);
        end
        default: ;
      endcase
    end

    // end-of-blank decision on the updated line count and vblank level
    lc_e = EW'(line_d);
    bl_e = EW'(blank_len_q);
    if (vblank_d) reach = lc_e >= bl_e;
    else reach = (bl_e >= EW'(vflt_pkg::UNDERSCAN_MAX))
                 && (lc_e >= bl_e - EW'(vflt_pkg::UNDERSCAN_MAX));
    jc_t   = (jo_t < TW'(vflt_pkg::JITTER_MAX)) ? jo_t : TW'(vflt_pkg::JITTER_MAX);
    base_t = (mode_q == vflt_pkg::MODE_FIXED) ? TW'(fix_start_q) : TW'(last_q);
    thr_t  = base_t + jc_t;
    lc_t   = TW'(line_d);

    if (do_decide) begin
      unique case (mode_q)
        vflt_pkg::MODE_FLOAT: begin
          if (reach) begin
            if (!item_i.garbage_frame && line_d == last_q) begin
              if (stable_q != '1) stable_d = stable_q + 1'b1;
            end else begin
              stable_d = '0;
            end
            last_d = line_d;
            tr = 1'b1;
          end
          if (32'(stable_d) >= vflt_pkg::STABLE_MIN) begin
            mode_d     = vflt_pkg::MODE_LOCK;
            locked_d   = '0;
            viol_cnt_d = '0;
          end
        end
        vflt_pkg::MODE_LOCK: begin
          if (line_d == last_q || reach) begin
            if (line_d == last_q && reach && !violated_q) begin
              viol_cnt_d = '0;
            end else begin
              if (!violated_q && viol_cnt_q != '1) viol_cnt_d = viol_cnt_q + 1'b1;
              violated_d = 1'b1;
            end
          end
          if (line_d == last_q) tr = 1'b1;
          if (32'(viol_cnt_d) > vflt_pkg::VIOLATIONS_MAX) begin
            mode_d   = vflt_pkg::MODE_FLOAT;
            stable_d = '0;
          end
        end
        default: tr = (thr_t < 0) || (lc_t >= thr_t);
      endcase
      if (tr) running_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_len_q <= '0;
      fix_start_q <= '0;
      step_q      <= vflt_pkg::JITTER_STEP_RST;
      mode_q      <= vflt_pkg::MODE_FLOAT;
      vblank_q    <= 1'b0;
      line_q      <= '0;
      last_q      <= '0;
      viol_cnt_q  <= '0;
      stable_q    <= '0;
      violated_q  <= 1'b0;
      running_q   <= 1'b0;
      locked_q    <= '0;
      jit_q       <= '0;
    end else begin
      blank_len_q <= blank_len_d;
      fix_start_q <= fix_start_d;
      step_q      <= step_d;
      mode_q      <= mode_d;
      vblank_q    <= vblank_d;
      line_q      <= line_d;
      last_q      <= last_d;
      viol_cnt_q  <= viol_cnt_d;
      stable_q    <= stable_d;
      violated_q  <= violated_d;
      running_q   <= running_d;
      locked_q    <= locked_d;
      jit_q       <= jit_d;
    end
  end

  assign res_o.leave_blank = tr;
  assign res_o.lock_mode   = mode_d;

endmodule

>>> rtl/vblank_frame_lock_tracker_unit.sv
// ---------------------------------------------------------------------------
// vblank_frame_lock_tracker_unit
// Line-by-line vertical blank exit and frame lock tracker, stream in/out.
// ---------------------------------------------------------------------------
// throughput: one word per cycle while the result register is free or drained, set by
// the combinational state update between the input register and the result register;
// an accepted word is held in the input register and its result in the result register
// reset: asynchronous, clears the valid flags and core state, jitter step to 2; word and result registers are not reset
module vblank_frame_lock_tracker_unit #(
  parameter int LINE_BITS = vflt_pkg::LINE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // vblank_level, garbage_frame,
                                                         // jitter_value, zero pad
  input  logic [vflt_pkg::OP_W-1:0]       s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // leave_blank, lock_mode, zero pad
  input  logic                            cfg_we_i,
  input  logic [vflt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vflt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic                 in_vld_q, in_vld_d;
  vflt_pkg::vflt_item_t in_item_q, in_item_d;
  logic                 out_vld_q, out_vld_d;
  vflt_pkg::vflt_res_t  out_res_q, out_res_d;
  vflt_pkg::vflt_res_t  res;
  logic                 adv;
  logic                 s_acc;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d  = s_acc || (in_vld_q && !adv);
    in_item_d = in_item_q;
    if (s_acc) begin
      in_item_d.operation     = s_axis_tuser;
      in_item_d.vblank_level  = s_axis_tdata[0];
      in_item_d.garbage_frame = s_axis_tdata[1];
      in_item_d.jitter_value  = $signed(s_axis_tdata[vflt_pkg::JIT_IN_W+1:2]);
    end
    out_vld_d = adv || (out_vld_q && !m_axis_tready);
    out_res_d = adv ? res : out_res_q;
  end

  vflt_core #(
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .item_i     (in_item_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_res_q.lock_mode, out_res_q.leave_blank};

endmodule
